// ===== rtl/edma_pkg.sv =====
`timescale 1ns / 1ps

package edma_pkg;

  // field widths
  localparam int ECHO_W      = 20;
  localparam int DIST_W      = 13;
  localparam int Q8_W        = DIST_W + 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  // width in us to q8 mm: q8 = floor(width * 12800 / 291)
  localparam int CONV_MUL_W = 14;
  localparam int CONV_DIV_W = 9;
  localparam int PROD_W     = ECHO_W + CONV_MUL_W;
  localparam logic [CONV_MUL_W-1:0] CONV_MUL = 14'd12800;
  localparam logic [CONV_DIV_W-1:0] CONV_DIV = 9'd291;

  // register map
  localparam logic CFG_ECHO_TIMEOUT = 1'b0;
  localparam logic CFG_MAX_DIST     = 1'b1;

  localparam logic [ECHO_W-1:0] ECHO_TIMEOUT_RST = 20'd30000;
  localparam logic [DIST_W-1:0] MAX_DIST_RST     = 13'd4000;

endpackage

// ===== rtl/edma_sdiv.sv =====
`timescale 1ns / 1ps

// bit-serial restoring divider, one quotient bit per cycle
module edma_sdiv #(
  parameter int N_W = 34,
  parameter int D_W = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,   // held stable while running
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int C_W = $clog2(N_W + 1);

  logic [N_W-1:0] q_r,    q_nxt;
  logic [D_W-1:0] rem_r,  rem_nxt;
  logic [C_W-1:0] cnt_r,  cnt_nxt;
  logic           done_r, done_nxt;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           ge;

  assign trial = {rem_r, q_r[N_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = C_W'(N_W);
    end else if (cnt_r != '0) begin
      q_nxt    = {q_r[N_W-2:0], ge};
      rem_nxt  = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == C_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/echo_distance_moving_average_unit.sv =====
`timescale 1ns / 1ps
// path to result valid: S_IDLE accepts, S_LOAD starts the conversion divider, S_CONV
//   waits for it, filtered items pass S_WIN, S_AVG0 and S_AVG (a divider over SUM_W - 8
//   bits, SUM_W = 21 + clog2(WINDOW + 1)) and all items end in S_DONE
// throughput: one item at a time; the next is accepted the cycle after the result loads
// reset: synchronous active-low rst_n empties the window, restores register
//   defaults (timeout 30000 us, max distance 4000 mm) and drops out_tvalid
module echo_distance_moving_average_unit import edma_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [19:0] echo_us, [23:20] zero
  input  logic                   in_tuser,   // [0] use_filter
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [12:0] distance_mm, [15:13] zero
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [0] timed_out, [1] clamped
  // configuration
  input  logic                   cfg_wr_en,
  input  logic                   cfg_addr,
  input  logic [ECHO_W-1:0]      cfg_wdata
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = Q8_W + CNT_W;
  localparam int NUM_W = SUM_W - 8;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_CONV = 7'b0000100,
    S_WIN  = 7'b0001000,
    S_AVG0 = 7'b0010000,
    S_AVG  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t            state_r,   state_nxt;
  logic [ECHO_W-1:0] tmo_r,     tmo_nxt;
  logic [DIST_W-1:0] maxd_r,    maxd_nxt;
  logic [ECHO_W-1:0] width_r,   width_nxt;
  logic              timed_r,   timed_nxt;
  logic              filt_r,    filt_nxt;
  logic [Q8_W-1:0]   q8_r,      q8_nxt;
  logic              clip_r,    clip_nxt;
  logic [DIST_W-1:0] dist_r,    dist_nxt;
  logic [CNT_W-1:0]  cnt_r,     cnt_nxt;
  logic [IDX_W-1:0]  old_r,     old_nxt;
  logic [SUM_W-1:0]  sum_r,     sum_nxt;
  logic              ovld_r,    ovld_nxt;
  logic [DIST_W-1:0] odist_r,   odist_nxt;
  logic              otimed_r,  otimed_nxt;
  logic              oclip_r,   oclip_nxt;

  // window samples, only read once written, so no reset
  logic [Q8_W-1:0]   win_r [WINDOW];
  logic              win_we;
  logic [IDX_W-1:0]  win_idx;
  // oldest sample, read every cycle; the window is never written while converting
  logic [Q8_W-1:0]   win_old_r;

  logic [ECHO_W-1:0] echo_in;
  logic              in_xfer;
  logic              out_free;

  logic              conv_start, conv_done;
  logic [PROD_W-1:0] conv_dividend, conv_q;
  logic              avg_start, avg_done;
  logic [SUM_W-1:0]  avg_rnd;
  logic [NUM_W-1:0]  avg_q;
  logic [Q8_W-1:0]   limit;
  logic              over;
  logic [Q8_W-1:0]   q8_clamped;

  assign echo_in   = in_tdata[ECHO_W-1:0];
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !ovld_r || out_tready;

  // width * 12800 / 291, one quotient bit per cycle
  assign conv_start    = (state_r == S_LOAD);
  assign conv_dividend = PROD_W'(width_r) * PROD_W'(CONV_MUL);

  edma_sdiv #(
    .N_W (PROD_W),
    .D_W (CONV_DIV_W)
  ) u_conv_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (conv_start),
    .dividend (conv_dividend),
    .divisor  (CONV_DIV),
    .done     (conv_done),
    .quotient (conv_q)
  );

  // clamp to max distance in q8
  assign limit      = {maxd_r, 8'd0};
  assign over       = conv_q > PROD_W'(limit);
  assign q8_clamped = over ? limit : conv_q[Q8_W-1:0];

  // rounded average: floor((sum + cnt*128) / 256) / cnt
  assign avg_start = (state_r == S_AVG0);
  assign avg_rnd   = sum_r + (SUM_W'(cnt_r) << 7);

  edma_sdiv #(
    .N_W (NUM_W),
    .D_W (CNT_W)
  ) u_avg_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (avg_start),
    .dividend (avg_rnd[SUM_W-1:8]),
    .divisor  (cnt_r),
    .done     (avg_done),
    .quotient (avg_q)
  );

  always_comb begin
    state_nxt  = state_r;
    tmo_nxt    = tmo_r;
    maxd_nxt   = maxd_r;
    width_nxt  = width_r;
    timed_nxt  = timed_r;
    filt_nxt   = filt_r;
    q8_nxt     = q8_r;
    clip_nxt   = clip_r;
    dist_nxt   = dist_r;
    cnt_nxt    = cnt_r;
    old_nxt    = old_r;
    sum_nxt    = sum_r;
    ovld_nxt   = ovld_r;
    odist_nxt  = odist_r;
    otimed_nxt = otimed_r;
    oclip_nxt  = oclip_r;
    win_we     = 1'b0;
    win_idx    = old_r;

    // register writes must only come while idle; the block itself does not enforce this
    if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_ECHO_TIMEOUT: tmo_nxt  = cfg_wdata;
        CFG_MAX_DIST:     maxd_nxt = cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end

    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          // no echo or echo past timeout uses the timeout width
          timed_nxt = (echo_in == '0) || (echo_in > tmo_r);
          width_nxt = timed_nxt ? tmo_r : echo_in;
          filt_nxt  = in_tuser;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_CONV;
      end
      S_CONV: begin
        if (conv_done) begin
          q8_nxt    = q8_clamped;
          clip_nxt  = over;
          dist_nxt  = q8_clamped[Q8_W-1:8];
          state_nxt = filt_r ? S_WIN : S_DONE;
        end
      end
      S_WIN: begin
        win_we = 1'b1;
        if (cnt_r < CNT_W'(WINDOW)) begin
          // still filling from empty
          win_idx = cnt_r[IDX_W-1:0];
          cnt_nxt = cnt_r + 1'b1;
          sum_nxt = sum_r + SUM_W'(q8_r);
        end else begin
          // full: replace the oldest sample
          win_idx = old_r;
          sum_nxt = sum_r - SUM_W'(win_old_r) + SUM_W'(q8_r);
          old_nxt = (old_r == IDX_W'(WINDOW - 1)) ? '0 : old_r + 1'b1;
        end
        state_nxt = S_AVG0;
      end
      S_AVG0: begin
        state_nxt = S_AVG;
      end
      S_AVG: begin
        if (avg_done) begin
          dist_nxt  = avg_q[DIST_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (out_free) begin
          ovld_nxt   = 1'b1;
          odist_nxt  = dist_r;
          otimed_nxt = timed_r;
          oclip_nxt  = clip_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tmo_r   <= ECHO_TIMEOUT_RST;
      maxd_r  <= MAX_DIST_RST;
      cnt_r   <= '0;
      old_r   <= '0;
      sum_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tmo_r   <= tmo_nxt;
      maxd_r  <= maxd_nxt;
      cnt_r   <= cnt_nxt;
      old_r   <= old_nxt;
      sum_r   <= sum_nxt;
      ovld_r  <= ovld_nxt;
    end
    width_r  <= width_nxt;
    timed_r  <= timed_nxt;
    filt_r   <= filt_nxt;
    q8_r     <= q8_nxt;
    clip_r   <= clip_nxt;
    dist_r   <= dist_nxt;
    odist_r  <= odist_nxt;
    otimed_r <= otimed_nxt;
    oclip_r  <= oclip_nxt;
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_r[win_idx] <= q8_r;
    end
    win_old_r <= win_r[old_r];
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {(OUT_TDATA_W - DIST_W)'(0), odist_r};
  assign out_tuser  = {oclip_r, otimed_r};

endmodule

// ===== rtl/edma_checker.sv =====
`timescale 1ns / 1ps

module edma_checker import edma_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one item in flight: ready drops after a transaction
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while busy");

  // a result cannot appear right after acceptance
  a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result too early");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // tdata padding stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:DIST_W] == '0)
    else $error("nonzero tdata padding");

endmodule

bind echo_distance_moving_average_unit edma_checker u_edma_checker (.*);
